// ===== rtl/mpps_pkg.sv =====
package mpps_pkg;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [1:0] REG_POLICY     = 2'd0;
	localparam logic [1:0] REG_QUANTUM    = 2'd1;
	localparam logic [1:0] REG_HIGH_FIRST = 2'd2;

	localparam logic [2:0] MODE_FCFS     = 3'd0;
	localparam logic [2:0] MODE_SJF      = 3'd1;
	localparam logic [2:0] MODE_SRTF     = 3'd2;
	localparam logic [2:0] MODE_PRIO     = 3'd3;
	localparam logic [2:0] MODE_PRIO_PRE = 3'd4;
	localparam logic [2:0] MODE_RR       = 3'd5;
	// spare codes behave as fcfs
	localparam logic [2:0] MODE_SPARE_6  = 3'd6;
	localparam logic [2:0] MODE_SPARE_7  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RING_LOAD,
		ST_SHIFT,
		ST_RANK,
		ST_HOLD,
		ST_POP,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear;
		logic flush;
		logic load;
		logic ring_load;
		logic ring_shift;
		logic rr_push;
		logic hold_push;
		logic pop;
		logic exec;
	} ctl_t;

	function automatic logic [15:0] sat16(input logic [32:0] v);
		return (v > 33'h0FFFF) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ===== rtl/mpps_cell.sv =====
module mpps_cell #(
	parameter int IDX = 0,
	parameter int N   = 16,
	parameter int TB  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpps_pkg::ctl_t                   ctl,
	input  logic [$clog2(N+1)-1:0]           count,
	input  logic [$clog2(N+1)-1:0]           fill,
	input  logic [$clog2(N+1)-1:0]           hold_rank,
	input  logic [$clog2(N)-1:0]             cur,
	input  logic                             holding,
	input  logic [$clog2(N)-1:0]             run_slot,
	input  logic                             run_ok,
	input  logic [TB-1:0]                    now,
	input  logic [2:0]                       mode,
	input  logic                             high_first,
	input  logic [7:0]                       ld_id,
	input  logic [TB-1:0]                    ld_arr,
	input  logic [15:0]                      ld_burst,
	input  logic [7:0]                       ld_prio,
	input  logic [((TB > 16) ? TB : 16)-1:0] tok_key_in,
	input  logic                             tok_elig_in,
	input  logic [$clog2(N)-1:0]             tok_idx_in,
	output logic [((TB > 16) ? TB : 16)-1:0] tok_key_out,
	output logic                             tok_elig_out,
	output logic [$clog2(N)-1:0]             tok_idx_out,
	output logic                             win,
	output logic                             elig,
	output logic                             head,
	output logic                             cur_live,
	output logic                             busy_after,
	output logic [7:0]                       id,
	output logic [TB-1:0]                    arr,
	output logic [15:0]                      burst,
	output logic [15:0]                      left,
	output logic                             started
);
	import mpps_pkg::*;

	localparam int KW = (TB > 16) ? TB : 16;
	localparam int CW = $clog2(N+1);
	localparam int SW = $clog2(N);

	logic [7:0]    id_q, prio_q;
	logic [TB-1:0] arr_q;
	logic [15:0]   burst_q, left_q;
	logic          started_q, queued_q, inq_q;
	logic [CW-1:0] rank_q, cnt_q;
	logic [KW-1:0] tok_key_q;
	logic          tok_elig_q;
	logic [SW-1:0] tok_idx_q;

	logic          valid, ready, is_cur, sel, prec, is_slot;
	logic [KW-1:0] key;

	assign valid   = CW'(IDX) < count;
	assign ready   = valid && (left_q != '0) && (arr_q <= now);
	assign is_cur  = cur == SW'(IDX);
	assign is_slot = count == CW'(IDX);
	assign sel     = run_ok && (run_slot == SW'(IDX));

	always_comb begin
		case (mode)
			MODE_SJF, MODE_SRTF:     key = KW'(left_q);
			MODE_PRIO, MODE_PRIO_PRE: key = KW'(high_first ? ~prio_q : prio_q);
			default:                 key = KW'(arr_q);
		endcase
	end

	assign elig = (mode == MODE_RR) ? (ready && !queued_q && !(holding && is_cur)) : ready;
	// earlier entry wins a tie
	assign prec = tok_elig_in &&
		((tok_key_in < key) || ((tok_key_in == key) && (tok_idx_in < SW'(IDX))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			queued_q  <= 1'b0;
			inq_q     <= 1'b0;
		end else begin
			if (ctl.clear) begin
				started_q <= 1'b0;
				queued_q  <= 1'b0;
				inq_q     <= 1'b0;
			end else if (ctl.flush) begin
				queued_q <= 1'b0;
				inq_q    <= 1'b0;
			end else if (ctl.load && is_slot) begin
				started_q <= 1'b0;
				queued_q  <= 1'b0;
			end else if (ctl.rr_push && elig) begin
				queued_q <= 1'b1;
				inq_q    <= 1'b1;
			end else if (ctl.hold_push && is_cur) begin
				queued_q <= 1'b1;
				inq_q    <= 1'b1;
			end else if (ctl.pop && inq_q && (rank_q == '0)) begin
				inq_q <= 1'b0;
			end else if (ctl.exec && sel) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && is_slot) begin
			id_q    <= ld_id;
			arr_q   <= ld_arr;
			burst_q <= ld_burst;
			left_q  <= ld_burst;
			prio_q  <= ld_prio;
		end
		if (ctl.exec && sel)
			left_q <= left_q - 16'd1;
		if (ctl.ring_load) begin
			tok_key_q  <= key;
			tok_elig_q <= elig;
			tok_idx_q  <= SW'(IDX);
			cnt_q      <= '0;
		end else if (ctl.ring_shift) begin
			tok_key_q  <= tok_key_in;
			tok_elig_q <= tok_elig_in;
			tok_idx_q  <= tok_idx_in;
			if (prec)
				cnt_q <= cnt_q + CW'(1);
		end
		if (ctl.rr_push && elig)
			rank_q <= fill + cnt_q;
		else if (ctl.hold_push && is_cur)
			rank_q <= hold_rank;
		else if (ctl.pop && inq_q && (rank_q != '0))
			rank_q <= rank_q - CW'(1);
	end

	assign tok_key_out  = tok_key_q;
	assign tok_elig_out = tok_elig_q;
	assign tok_idx_out  = tok_idx_q;
	assign win          = elig && (cnt_q == '0);
	assign head         = inq_q && (rank_q == '0);
	assign cur_live     = is_cur && valid && (left_q != '0);
	assign busy_after   = valid && (left_q != '0) && !(sel && (left_q == 16'd1));
	assign id           = id_q;
	assign arr          = arr_q;
	assign burst        = burst_q;
	assign left         = left_q;
	assign started      = started_q;

endmodule

// ===== rtl/multi_policy_process_scheduler.sv =====
// Process scheduler over a table of MAX_PROCS entries held in a ring of cells.
// Load and clear are taken in the idle state. A tick runs through ring load,
// shift, rank, hold, pop and exec: every cell's key token travels once around
// the ring while each cell counts the eligible entries that beat it; then rank,
// hold and pop settle the round robin queue and the choice, and exec updates the
// chosen entry and presents the result once the output is free. The result sits
// in an output register, so the next command is taken while it waits.
module multi_policy_process_scheduler #(
	parameter int MAX_PROCS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  proc_id,
	input  logic [15:0] arrive_time,
	input  logic [15:0] burst_len,
	input  logic [7:0]  prio_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] tick_time,
	output logic        cpu_idle,
	output logic [7:0]  run_id,
	output logic        first_dispatch,
	output logic [15:0] response_time,
	output logic        finished,
	output logic [15:0] turnaround,
	output logic [15:0] waiting,
	output logic        all_done
);
	import mpps_pkg::*;

	localparam int N  = MAX_PROCS;
	localparam int TB = TIME_BITS;
	localparam int KW = (TB > 16) ? TB : 16;
	localparam int MW = KW + 1;
	localparam int CW = $clog2(N+1);
	localparam int SW = $clog2(N);

	state_t        state_q, state_d;
	ctl_t          ctl;
	logic [2:0]    policy_q, mode;
	logic [7:0]    quantum_q, q_eff;
	logic          hf_q;
	logic [CW-1:0] count_q, fill_q, new_cnt;
	logic [TB-1:0] now_q, next_now, ld_arr;
	logic [SW-1:0] cur_q, shift_q, run_slot_q, win_slot, head_slot;
	logic          holding_q, run_ok_q;
	logic [7:0]    slice_q;
	logic          in_acc, out_free, is_rr, pop_now, cur_live_any, do_hold_push;

	logic [15:0] tick_q, resp_q, tat_q, wait_q;
	logic        out_valid_q, idle_q, fd_q, fin_q, done_q;
	logic [7:0]  run_id_q;

	logic [N-1:0][KW-1:0] c_key;
	logic [N-1:0]         c_tok_elig, c_win, c_elig, c_head, c_cur_live, c_busy, c_started;
	logic [N-1:0][SW-1:0] c_idx;
	logic [N-1:0][7:0]    c_id;
	logic [N-1:0][TB-1:0] c_arr;
	logic [N-1:0][15:0]   c_burst, c_left;

	logic [TB-1:0] arr_r;
	logic [15:0]   burst_r, left_r;
	logic [MW-1:0] tat_w, wait_w, ld_arr_w;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mode     = (policy_q > MODE_RR) ? MODE_FCFS : policy_q;
	assign is_rr    = mode == MODE_RR;
	assign q_eff    = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
	assign pop_now  = !holding_q && (fill_q != '0);
	assign next_now = (now_q == {TB{1'b1}}) ? now_q : now_q + TB'(1);

	assign ld_arr_w = MW'(arrive_time);
	assign ld_arr   = (ld_arr_w > MW'({TB{1'b1}})) ? {TB{1'b1}} : TB'(ld_arr_w);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			localparam int PREV = (g == 0) ? N - 1 : g - 1;
			mpps_cell #(.IDX(g), .N(N), .TB(TB)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.count       (count_q),
				.fill        (fill_q),
				.hold_rank   (fill_q),
				.cur         (cur_q),
				.holding     (holding_q),
				.run_slot    (run_slot_q),
				.run_ok      (run_ok_q),
				.now         (now_q),
				.mode        (mode),
				.high_first  (hf_q),
				.ld_id       (proc_id),
				.ld_arr      (ld_arr),
				.ld_burst    (burst_len),
				.ld_prio     (prio_level),
				.tok_key_in  (c_key[PREV]),
				.tok_elig_in (c_tok_elig[PREV]),
				.tok_idx_in  (c_idx[PREV]),
				.tok_key_out (c_key[g]),
				.tok_elig_out(c_tok_elig[g]),
				.tok_idx_out (c_idx[g]),
				.win         (c_win[g]),
				.elig        (c_elig[g]),
				.head        (c_head[g]),
				.cur_live    (c_cur_live[g]),
				.busy_after  (c_busy[g]),
				.id          (c_id[g]),
				.arr         (c_arr[g]),
				.burst       (c_burst[g]),
				.left        (c_left[g]),
				.started     (c_started[g])
			);
		end
	endgenerate

	// one-hot to index
	always_comb begin
		win_slot  = '0;
		head_slot = '0;
		for (int i = 0; i < N; i++) begin
			if (c_win[i])
				win_slot = win_slot | SW'(i);
			if (c_head[i])
				head_slot = head_slot | SW'(i);
		end
	end

	assign new_cnt      = CW'($countones(c_elig));
	assign cur_live_any = |c_cur_live;
	assign do_hold_push = is_rr && holding_q && cur_live_any && (slice_q >= q_eff);

	assign arr_r   = c_arr[run_slot_q];
	assign burst_r = c_burst[run_slot_q];
	assign left_r  = c_left[run_slot_q];
	assign tat_w   = MW'(next_now - arr_r);
	assign wait_w  = (tat_w >= MW'(burst_r)) ? tat_w - MW'(burst_r) : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_acc && (command == CMD_TICK)) state_d = ST_RING_LOAD;
			ST_RING_LOAD: state_d = ST_SHIFT;
			ST_SHIFT:     if (shift_q == SW'(N - 2)) state_d = ST_RANK;
			ST_RANK:      state_d = ST_HOLD;
			ST_HOLD:      state_d = ST_POP;
			ST_POP:       state_d = ST_EXEC;
			ST_EXEC:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		in_stall  = state_q != ST_IDLE;
		ctl.flush = cfg_we && (cfg_index == REG_POLICY);
		case (state_q)
			ST_IDLE: begin
				ctl.load  = in_valid && (command == CMD_LOAD) && (burst_len != 16'd0) &&
					(count_q < CW'(N));
				ctl.clear = in_valid && (command == CMD_CLEAR);
			end
			ST_RING_LOAD: ctl.ring_load = 1'b1;
			ST_SHIFT:     ctl.ring_shift = 1'b1;
			ST_RANK:      ctl.rr_push = is_rr;
			ST_HOLD:      ctl.hold_push = do_hold_push;
			ST_POP:       ctl.pop = is_rr && pop_now;
			ST_EXEC:      ctl.exec = out_free;
			default:      ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= MODE_FCFS;
			quantum_q   <= 8'd2;
			hf_q        <= 1'b0;
			count_q     <= '0;
			now_q       <= '0;
			cur_q       <= '0;
			holding_q   <= 1'b0;
			slice_q     <= '0;
			fill_q      <= '0;
			shift_q     <= '0;
			run_slot_q  <= '0;
			run_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_POLICY: begin
						policy_q  <= cfg_data[2:0];
						cur_q     <= '0;
						holding_q <= 1'b0;
						slice_q   <= '0;
						fill_q    <= '0;
					end
					REG_QUANTUM:    quantum_q <= cfg_data;
					REG_HIGH_FIRST: hf_q <= cfg_data[0];
					default:        ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.load)
						count_q <= count_q + CW'(1);
					if (ctl.clear) begin
						count_q   <= '0;
						now_q     <= '0;
						cur_q     <= '0;
						holding_q <= 1'b0;
						slice_q   <= '0;
						fill_q    <= '0;
					end
				end
				ST_RING_LOAD: shift_q <= '0;
				ST_SHIFT:     shift_q <= shift_q + SW'(1);
				ST_RANK: begin
					if (is_rr) begin
						fill_q <= fill_q + new_cnt;
					end else if ((mode != MODE_SRTF) && (mode != MODE_PRIO_PRE) &&
						holding_q && cur_live_any) begin
						// non-preemptive holder keeps the cpu
						run_slot_q <= cur_q;
						run_ok_q   <= 1'b1;
					end else begin
						run_slot_q <= win_slot;
						run_ok_q   <= |c_win;
					end
				end
				ST_HOLD: begin
					if (is_rr) begin
						if (do_hold_push) begin
							fill_q    <= fill_q + CW'(1);
							holding_q <= 1'b0;
						end else begin
							holding_q <= holding_q && cur_live_any;
						end
					end
				end
				ST_POP: begin
					if (is_rr) begin
						run_slot_q <= pop_now ? head_slot : cur_q;
						run_ok_q   <= pop_now || holding_q;
						if (pop_now) begin
							holding_q <= 1'b1;
							cur_q     <= head_slot;
							slice_q   <= '0;
							fill_q    <= fill_q - CW'(1);
						end
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						now_q       <= next_now;
						if (!run_ok_q) begin
							if (!is_rr)
								holding_q <= 1'b0;
						end else begin
							if ((run_slot_q != cur_q) || !holding_q)
								slice_q <= 8'd1;
							else if (slice_q != 8'hFF)
								slice_q <= slice_q + 8'd1;
							cur_q     <= run_slot_q;
							holding_q <= left_r != 16'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EXEC) && out_free) begin
			tick_q   <= sat16(33'(now_q));
			idle_q   <= !run_ok_q;
			done_q   <= !(|c_busy);
			run_id_q <= run_ok_q ? c_id[run_slot_q] : 8'd0;
			fd_q     <= run_ok_q && !c_started[run_slot_q];
			resp_q   <= (run_ok_q && !c_started[run_slot_q]) ?
				sat16(33'(now_q - arr_r)) : 16'd0;
			fin_q    <= run_ok_q && (left_r == 16'd1);
			tat_q    <= (run_ok_q && (left_r == 16'd1)) ? sat16(33'(tat_w)) : 16'd0;
			wait_q   <= (run_ok_q && (left_r == 16'd1)) ? sat16(33'(wait_w)) : 16'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign tick_time      = tick_q;
	assign cpu_idle       = idle_q;
	assign run_id         = run_id_q;
	assign first_dispatch = fd_q;
	assign response_time  = resp_q;
	assign finished       = fin_q;
	assign turnaround     = tat_q;
	assign waiting        = wait_q;
	assign all_done       = done_q;

endmodule

// ===== rtl/mpps_checker.sv =====
module mpps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] tick_time,
	input logic        cpu_idle,
	input logic [7:0]  run_id,
	input logic        first_dispatch,
	input logic [15:0] response_time,
	input logic        finished,
	input logic [15:0] turnaround,
	input logic [15:0] waiting
);

	// a stalled transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tick_time) && $stable(run_id))
		else $error("result changed while stalled");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cpu_idle |-> run_id == 8'd0 && !first_dispatch && !finished)
		else $error("idle tick reports a process");

	a_resp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_dispatch |-> response_time == 16'd0)
		else $error("response time without first dispatch");

	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> turnaround == 16'd0 && waiting == 16'd0)
		else $error("completion times without completion");

endmodule

bind multi_policy_process_scheduler mpps_checker u_mpps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.tick_time     (tick_time),
	.cpu_idle      (cpu_idle),
	.run_id        (run_id),
	.first_dispatch(first_dispatch),
	.response_time (response_time),
	.finished      (finished),
	.turnaround    (turnaround),
	.waiting       (waiting)
);

// ===== tb/tb_multi_policy_process_scheduler.sv =====
module tb_multi_policy_process_scheduler;
	import mpps_pkg::*;

	localparam int NPROC = 16;
	localparam logic [15:0] TMAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] tick_time;
		logic        cpu_idle;
		logic [7:0]  run_id;
		logic        first_dispatch;
		logic [15:0] response_time;
		logic        finished;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic        all_done;
	} tick_rpt_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [7:0]  proc_id = '0;
	logic [15:0] arrive_time = '0;
	logic [15:0] burst_len = '0;
	logic [7:0]  prio_level = '0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [15:0] tick_time;
	logic        cpu_idle;
	logic [7:0]  run_id;
	logic        first_dispatch;
	logic [15:0] response_time;
	logic        finished;
	logic [15:0] turnaround;
	logic [15:0] waiting;
	logic        all_done;

	multi_policy_process_scheduler i_dut (.*);

	always #5 clk = ~clk;

	// scheduler shadow state
	logic [2:0]  pol_mode = MODE_FCFS;
	logic [7:0]  slice_len = 8'd2;
	logic        prefer_high = 0;
	logic [7:0]  tab_id [NPROC];
	logic [15:0] tab_arr [NPROC];
	logic [15:0] tab_burst [NPROC];
	logic [7:0]  tab_prio [NPROC];
	logic [15:0] tab_left [NPROC];
	logic        tab_started [NPROC];
	logic        tab_queued [NPROC];
	int          tab_count;
	logic [15:0] clock_now;
	int          cur_slot;
	logic        holding;
	int          slice_cnt;
	int          ready_q[$];

	tick_rpt_t   expected_ticks[$];
	int          errors = 0;
	bit          drain_on = 0;
	int          next_gap = 0;
	bit          valid_held = 0;

	function automatic void release_cpu();
		ready_q.delete();
		for (int i = 0; i < NPROC; i++) tab_queued[i] = 0;
		holding = 0;
		cur_slot = 0;
		slice_cnt = 0;
	endfunction

	function automatic void wipe_table();
		release_cpu();
		for (int i = 0; i < NPROC; i++) tab_started[i] = 0;
		tab_count = 0;
		clock_now = 0;
	endfunction

	function automatic bit runnable(int i);
		return tab_left[i] > 0 && tab_arr[i] <= clock_now;
	endfunction

	function automatic bit wins(logic [2:0] m, int a, int b);
		if (m == MODE_SJF || m == MODE_SRTF) return tab_left[a] < tab_left[b];
		if (m == MODE_PRIO || m == MODE_PRIO_PRE)
			return prefer_high ? tab_prio[a] > tab_prio[b] : tab_prio[a] < tab_prio[b];
		return tab_arr[a] < tab_arr[b];
	endfunction

	function automatic int best_ready(logic [2:0] m);
		int best;
		best = -1;
		for (int i = 0; i < tab_count; i++)
			if (runnable(i) && (best < 0 || wins(m, i, best))) best = i;
		return best;
	endfunction

	function automatic int rr_next();
		int q;
		int best;
		int s;
		q = (slice_len == 0) ? 1 : slice_len;
		forever begin
			best = -1;
			for (int i = 0; i < tab_count; i++) begin
				if (!runnable(i) || tab_queued[i]) continue;
				if (holding && cur_slot == i) continue;
				if (best < 0 || tab_arr[i] < tab_arr[best]) best = i;
			end
			if (best < 0) break;
			tab_queued[best] = 1;
			if (ready_q.size() < NPROC) ready_q = {ready_q, best};
		end
		if (holding && (cur_slot >= tab_count || tab_left[cur_slot] == 0)) holding = 0;
		if (holding && slice_cnt >= q) begin
			tab_queued[cur_slot] = 1;
			if (ready_q.size() < NPROC) ready_q = {ready_q, cur_slot};
			holding = 0;
		end
		while (!holding && ready_q.size() > 0) begin
			s = ready_q.pop_front();
			if (s < tab_count && tab_left[s] > 0) begin
				cur_slot = s;
				holding = 1;
				slice_cnt = 0;
			end
		end
		return holding ? cur_slot : -1;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [7:0] val);
		if (idx == REG_POLICY) begin
			pol_mode = val[2:0];
			release_cpu();
		end else if (idx == REG_QUANTUM) slice_len = val;
		else if (idx == REG_HIGH_FIRST) prefer_high = val[0];
	endfunction

	// advance the shadow scheduler by one accepted command
	function automatic void schedule_cmd(logic [1:0] cmd, logic [7:0] pid,
			logic [15:0] arr, logic [15:0] bur, logic [7:0] pr);
		tick_rpt_t r;
		logic [2:0] m;
		int run;
		int tat;
		logic [15:0] nxt;
		bit all;
		if (cmd == CMD_LOAD) begin
			if (bur == 0 || tab_count >= NPROC) return;
			tab_id[tab_count] = pid;
			tab_arr[tab_count] = arr;
			tab_burst[tab_count] = bur;
			tab_left[tab_count] = bur;
			tab_prio[tab_count] = pr;
			tab_started[tab_count] = 0;
			tab_queued[tab_count] = 0;
			tab_count++;
			return;
		end
		if (cmd == CMD_CLEAR) begin
			wipe_table();
			return;
		end
		if (cmd != CMD_TICK) return;
		r = '0;
		r.tick_time = clock_now;
		m = (pol_mode > MODE_RR) ? MODE_FCFS : pol_mode;
		if (m == MODE_RR) run = rr_next();
		else if (m == MODE_SRTF || m == MODE_PRIO_PRE) run = best_ready(m);
		else if (holding && cur_slot < tab_count && tab_left[cur_slot] > 0) run = cur_slot;
		else run = best_ready(m);
		nxt = (clock_now == TMAX) ? TMAX : clock_now + 16'd1;
		if (run < 0) begin
			r.cpu_idle = 1;
			if (m != MODE_RR) holding = 0;
		end else begin
			if (run != cur_slot || !holding) slice_cnt = 0;
			cur_slot = run;
			holding = 1;
			r.run_id = tab_id[run];
			if (!tab_started[run]) begin
				tab_started[run] = 1;
				r.first_dispatch = 1;
				r.response_time = clock_now - tab_arr[run];
			end
			tab_left[run]--;
			if (slice_cnt < 255) slice_cnt++;
			if (tab_left[run] == 0) begin
				tat = int'(nxt) - int'(tab_arr[run]);
				r.finished = 1;
				r.turnaround = 16'(tat);
				r.waiting = 16'((tat >= int'(tab_burst[run])) ? tat - int'(tab_burst[run]) : 0);
				holding = 0;
			end
		end
		clock_now = nxt;
		all = 1;
		for (int i = 0; i < tab_count; i++) if (tab_left[i] > 0) all = 0;
		r.all_done = all;
		expected_ticks = {expected_ticks, r};
	endfunction

	// valid stays high into the next transfer when the next gap is zero
	task automatic send_cmd(logic [1:0] cmd, logic [7:0] pid = '0,
			logic [15:0] arr = '0, logic [15:0] bur = '0, logic [7:0] pr = '0);
		repeat (next_gap) @(posedge clk);
		in_valid <= 1;
		command <= cmd;
		proc_id <= pid;
		arrive_time <= arr;
		burst_len <= bur;
		prio_level <= pr;
		do @(posedge clk); while (in_stall);
		schedule_cmd(cmd, pid, arr, bur, pr);
		next_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
		valid_held = (next_gap == 0);
		if (!valid_held)
			in_valid <= 0;
	endtask

	task automatic drain();
		if (valid_held) begin
			in_valid <= 0;
			valid_held = 0;
		end
		while (expected_ticks.size() > 0) @(posedge clk);
		// a load or clear may still be in flight after the last tick result
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		apply_reg(idx, val);
	endtask

	task automatic tick_n(int n);
		repeat (n) send_cmd(CMD_TICK);
	endtask

	// result checker with random receive stalls
	always @(posedge clk) begin
		tick_rpt_t got, exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = '{tick_time, cpu_idle, run_id, first_dispatch, response_time,
				finished, turnaround, waiting, all_done};
			if (expected_ticks.size() == 0) begin
				$display("%0t unexpected tick result %p", $time, got);
				errors++;
			end else begin
				exp_r = expected_ticks.pop_front();
				if (got !== exp_r) begin
					$display("%0t mismatch expected %p actual %p", $time, exp_r, got);
					errors++;
				end
			end
		end
	end

	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			out_stall <= 0;
			@(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				w = $urandom_range(0, 11);
				if (w > 0) begin
					out_stall <= 1;
					repeat (w) @(posedge clk);
				end
			end
		end
	end

	task automatic test_directed();
		send_cmd(CMD_TICK);
		send_cmd(CMD_LOAD, 8'hFF, 16'd0, 16'd3, 8'd0);
		send_cmd(CMD_LOAD, 8'h00, 16'd1, 16'd0, 8'd9);
		send_cmd(CMD_LOAD, 8'h55, 16'd1, 16'd1, 8'hFF);
		send_cmd(CMD_LOAD, 8'hAA, 16'd2, 16'd2, 8'h80);
		send_cmd(CMD_NONE, 8'h12, 16'd0, 16'd5, 8'd0);
		tick_n(8);
		send_cmd(CMD_CLEAR);
		send_cmd(CMD_LOAD, 8'h01, 16'hFFFF, 16'hFFFF, 8'h7F);
		send_cmd(CMD_LOAD, 8'h02, 16'h0002, 16'h0001, 8'h01);
		tick_n(5);
		send_cmd(CMD_CLEAR);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < NPROC + 2; i++)
			send_cmd(CMD_LOAD, 8'(i), 16'($urandom_range(0, 3)),
				16'($urandom_range(1, 3)), 8'(i));
		tick_n(6);
		send_cmd(CMD_CLEAR);
	endtask

	// table of a few processes, then enough ticks to finish most of them
	task automatic random_batch();
		int n;
		int t;
		int len;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_cmd(CMD_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
					8'($urandom));
			else
				send_cmd(CMD_LOAD, 8'($urandom), 16'($urandom_range(0, 8)),
					16'($urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 5)),
					8'($urandom));
		end
		t = $urandom_range(4, 22);
		for (int i = 0; i < t; i++) begin
			if ($urandom_range(0, 25) == 0)
				send_cmd(CMD_LOAD, 8'($urandom), 16'($urandom_range(0, 20)),
					16'($urandom_range(1, 4)), 8'($urandom));
			else if ($urandom_range(0, 40) == 0) send_cmd(CMD_NONE, 8'($urandom));
			else send_cmd(CMD_TICK);
		end
		send_cmd(CMD_CLEAR);
	endtask

	task automatic test_policies();
		logic [2:0] modes [8];
		modes = '{MODE_FCFS, MODE_SJF, MODE_SRTF, MODE_PRIO, MODE_PRIO_PRE,
			MODE_RR, MODE_SPARE_6, MODE_SPARE_7};
		foreach (modes[k]) begin
			write_reg(REG_POLICY, 8'(modes[k]));
			write_reg(REG_HIGH_FIRST, 8'(k % 2));
			write_reg(REG_QUANTUM, (k == 5) ? 8'd1 : 8'($urandom_range(1, 4)));
			repeat (2) random_batch();
		end
		write_reg(REG_QUANTUM, 8'd0);
		write_reg(REG_POLICY, 8'(MODE_RR));
		repeat (2) random_batch();
		write_reg(REG_QUANTUM, 8'd255);
		repeat (1) random_batch();
	endtask

	task automatic test_time_saturation();
		write_reg(REG_POLICY, 8'(MODE_FCFS));
		send_cmd(CMD_LOAD, 8'h3C, 16'd0, 16'hFFFF, 8'd0);
		send_cmd(CMD_LOAD, 8'h3D, 16'd0, 16'd1, 8'd0);
		tick_n(3);
		send_cmd(CMD_CLEAR);
	endtask

	task automatic test_random_mix();
		repeat (2) begin
			write_reg(REG_POLICY, 8'($urandom_range(0, 7)));
			write_reg(REG_HIGH_FIRST, 8'($urandom_range(0, 1)));
			write_reg(REG_QUANTUM, 8'($urandom_range(0, 5)));
			random_batch();
			random_batch();
		end
	endtask

	initial begin
		wipe_table();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_time_saturation();
		test_policies();
		test_random_mix();
		drain();
		if (errors == 0 && expected_ticks.size() == 0) begin
			$display("[multi_policy_process_scheduler] OK");
		end else begin
			$display("[multi_policy_process_scheduler] ERROR");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("[multi_policy_process_scheduler] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mpps_pkg.sv
rtl/mpps_cell.sv
rtl/multi_policy_process_scheduler.sv
rtl/mpps_checker.sv
tb/tb_multi_policy_process_scheduler.sv
